// ----- rtl/core/plist_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and codes for the positional list core: request codes, status
// codes, field widths and the control bundle that drives the cell chain.
// ----------------------------------------------------------------------------
package plist_pkg;

	// field widths
	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;

	// request codes
	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	// found position when nothing matched
	localparam logic signed [POS_W-1:0] NO_POSITION = -5'sd1;

	// match bits examined per cycle during a find
	localparam int GROUP      = 8;
	localparam int GROUP_BITS = 3;

	// shift commands to every cell of the chain
	typedef struct packed {
		logic shift_in;   // open a slot at the position, later entries move up
		logic shift_out;  // close the slot at the position, later entries move down
	} plist_ctl_t;

endpackage : plist_pkg
`default_nettype wire

// ----- rtl/core/plist_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_if
// Valid/ready channels of the positional list core: request and response.
// ----------------------------------------------------------------------------
interface plist_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] value;
	logic [4:0]         position;

	modport source (output valid, output op, output value, output position, input ready);
	modport sink   (input valid, input op, input value, input position, output ready);
endinterface : plist_req_if

interface plist_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [4:0] found_position;
	logic [1:0]        status;
	logic [4:0]        length;

	modport source (output valid, output found_position, output status, output length,
		input ready);
	modport sink   (input valid, input found_position, input status, input length,
		output ready);
endinterface : plist_rsp_if
`default_nettype wire

// ----- rtl/core/plist_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_cell
// One slot of the list. Takes the new value, its left neighbour's value or its
// right neighbour's value on a shift, and compares its value for a find.
// ----------------------------------------------------------------------------
module plist_cell
	import plist_pkg::*;
#(
	parameter int IDX = 0,
	parameter int MW  = 5
) (
	input  wire logic                clk,
	input  wire plist_ctl_t          ctl,
	input  wire logic [MW-1:0]       pos,
	input  wire logic [MW-1:0]       count,
	input  wire logic [VALUE_W-1:0]  value,
	input  wire logic [VALUE_W-1:0]  left_data,
	input  wire logic [VALUE_W-1:0]  right_data,
	output logic [VALUE_W-1:0]       data,
	output logic                     hit
);

	localparam logic [MW-1:0] MY_IDX = MW'(IDX);

	logic [VALUE_W-1:0] data_q;

	// slot contents move with inserts and removals
	always_ff @(posedge clk) begin
		if (ctl.shift_in) begin
			if (MY_IDX == pos) begin
				data_q <= value;
			end else if (MY_IDX > pos) begin
				data_q <= left_data;
			end
		end else if (ctl.shift_out) begin
			if (MY_IDX >= pos) begin
				data_q <= right_data;
			end
		end
	end

	assign data = data_q;

	// only occupied slots take part in a find
	assign hit = (MY_IDX < count) && (data_q == value);

endmodule : plist_cell
`default_nettype wire

// ----- rtl/core/positional_list_insert_remove_find_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Append, insert and remove: the response register is loaded at the accepting
// edge, and the cell chain shifts in that same cycle.
// Find: the match bits of all cells are latched at the accepting edge, then
// one group of 8 match bits is scanned per cycle until a hit or the last group.
// Reset empties the list at once; stored values are left as they were.
// ----------------------------------------------------------------------------
// positional_list_insert_remove_find_core
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of cells,
// with append, insert at position, remove at position and find first match.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_find_core
	import plist_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	plist_req_if.sink   req,
	plist_rsp_if.source rsp
);

	localparam int CNTW   = $clog2(CAPACITY + 1);
	localparam int MW     = (CNTW > POS_W) ? CNTW : POS_W;
	localparam int NCHUNK = (CAPACITY + GROUP - 1) / GROUP;
	localparam int MLEN   = NCHUNK * GROUP;
	localparam int BW     = $clog2(MLEN);
	localparam int LW     = $clog2(NCHUNK + 1);

	localparam logic [CNTW-1:0] CAP_CNT = CNTW'(CAPACITY);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic                     state_q;
	logic [CNTW-1:0]          count_q;
	logic [MLEN-1:0]          match_q;
	logic [BW-1:0]            base_q;
	logic [LW-1:0]            left_q;
	logic                     rsp_valid_q;
	logic signed [POS_W-1:0]  rsp_found_q;
	logic [STATUS_W-1:0]      rsp_status_q;
	logic [POS_W-1:0]         rsp_length_q;

	logic                     accept;
	logic                     full;
	logic [MW-1:0]            pos_x;
	logic [MW-1:0]            cnt_x;
	plist_ctl_t               ctl;
	logic [MW-1:0]            shift_pos;
	logic [STATUS_W-1:0]      req_status;
	logic [CAPACITY-1:0]      hits;
	logic [VALUE_W-1:0]       cell_data [CAPACITY];
	logic [GROUP-1:0]         chunk;
	logic                     chunk_hit;
	logic [GROUP_BITS-1:0]    chunk_off;
	logic [CNTW-1:0]          count_next;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign full  = (count_q >= CAP_CNT);
	assign pos_x = MW'(req.position);
	assign cnt_x = MW'(count_q);

	// decode the request into a shift command and a status
	always_comb begin
		ctl        = '0;
		shift_pos  = pos_x;
		req_status = ST_OK;
		unique case (req.op)
			OP_APPEND: begin
				shift_pos = cnt_x;
				if (full) begin
					req_status = ST_FULL;
				end else begin
					ctl.shift_in = accept;
				end
			end
			OP_INSERT: begin
				if (full) begin
					req_status = ST_FULL;
				end else if (pos_x > cnt_x) begin
					req_status = ST_RANGE;
				end else begin
					ctl.shift_in = accept;
				end
			end
			OP_REMOVE: begin
				if (pos_x >= cnt_x) begin
					req_status = ST_RANGE;
				end else begin
					ctl.shift_out = accept;
				end
			end
			OP_FIND: begin
				req_status = ST_NOTFOUND;
			end
			default: begin
				req_status = ST_OK;
			end
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (ctl.shift_in) begin
			count_next = count_q + CNTW'(1);
		end else if (ctl.shift_out) begin
			count_next = count_q - CNTW'(1);
		end
	end

	// chain of cells, each fed by its neighbours (zero at either end of the chain)
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] left_data;
		logic [VALUE_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_inner_l
			assign left_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_inner_r
			assign right_data = cell_data[i+1];
		end

		plist_cell #(
			.IDX (i),
			.MW  (MW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.pos        (shift_pos),
			.count      (cnt_x),
			.value      (req.value),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[i]),
			.hit        (hits[i])
		);
	end

	// first set bit of the current group of match bits
	assign chunk     = match_q[GROUP-1:0];
	assign chunk_hit = |chunk;
	always_comb begin
		chunk_off = '0;
		for (int k = GROUP - 1; k >= 0; k--) begin
			if (chunk[k]) begin
				chunk_off = GROUP_BITS'(k);
			end
		end
	end

	// control: state, list length, scan bookkeeping, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			left_q      <= '0;
		end else begin
			count_q <= count_next;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.op == OP_FIND) begin
							state_q <= S_SCAN;
							left_q  <= LW'(NCHUNK);
						end else begin
							rsp_valid_q <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (chunk_hit || left_q == LW'(1)) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
					end else begin
						left_q <= left_q - LW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// match bits and response beat payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			if (accept) begin
				match_q      <= MLEN'(hits);
				base_q       <= '0;
				rsp_found_q  <= NO_POSITION;
				rsp_status_q <= req_status;
				rsp_length_q <= POS_W'(count_next);
			end
		end else begin
			match_q <= match_q >> GROUP;
			base_q  <= base_q + BW'(GROUP);
			if (chunk_hit) begin
				rsp_found_q  <= POS_W'(base_q + BW'(chunk_off));
				rsp_status_q <= ST_OK;
			end else begin
				rsp_found_q  <= NO_POSITION;
				rsp_status_q <= ST_NOTFOUND;
			end
			rsp_length_q <= POS_W'(count_q);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.found_position = rsp_found_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.length         = rsp_length_q;

endmodule : positional_list_insert_remove_find_core
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list core. Requests go in through the
// request channel with random gaps. A software copy of the list predicts each
// response at the beat that accepts its request. A checker compares every
// response beat, field by field, with the oldest prediction. Covered: empty
// and full lists, out of range positions, the value extremes, a no-gap
// stretch and a long response stall.
// ----------------------------------------------------------------------------
module tb;
	import plist_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int IDLE_PCT    = 34;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 20;

	typedef struct {
		logic signed [POS_W-1:0] found_position;
		logic [STATUS_W-1:0]     status;
		logic [POS_W-1:0]        length;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	plist_req_if req ();
	plist_rsp_if rsp ();

	positional_list_insert_remove_find_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// software copy of the list and the responses still owed by the core
	logic signed [VALUE_W-1:0] model_vals[CAPACITY];
	int unsigned               model_len;
	list_rsp_t                 pending_rsp[$];

	int mismatches    = 0;
	int req_idle_pct  = IDLE_PCT;
	int rsp_idle_pct  = IDLE_PCT;
	int hold_requests = 0;
	bit grow_list     = 1'b1;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// next response for one request, updating the list copy
	function automatic list_rsp_t list_predict(logic [OP_W-1:0] op,
		logic signed [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
		list_rsp_t r;
		int        i;
		r.found_position = NO_POSITION;
		r.status         = ST_OK;
		case (op)
			OP_APPEND, OP_INSERT: begin
				if (model_len >= CAPACITY)
					r.status = ST_FULL;
				else if (op == OP_INSERT && pos > model_len)
					r.status = ST_RANGE;
				else begin
					if (op == OP_APPEND)
						pos = model_len[POS_W-1:0];
					for (i = model_len; i > pos; i--)
						model_vals[i] = model_vals[i-1];
					model_vals[pos] = value;
					model_len++;
				end
			end
			OP_REMOVE: begin
				if (pos >= model_len)
					r.status = ST_RANGE;
				else begin
					for (i = pos; i + 1 < model_len; i++)
						model_vals[i] = model_vals[i+1];
					model_len--;
				end
			end
			default: begin
				r.status = ST_NOTFOUND;
				for (i = 0; i < model_len; i++) begin
					if (model_vals[i] == value) begin
						r.found_position = i[POS_W-1:0];
						r.status         = ST_OK;
						break;
					end
				end
			end
		endcase
		r.length = model_len[POS_W-1:0];
		return r;
	endfunction

	// offer one request beat, maybe after a gap, and predict its response
	task automatic send_req(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value,
		logic [POS_W-1:0] pos);
		if ($urandom_range(99) < req_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.op       <= op;
		req.value    <= value;
		req.position <= pos;
		do @(posedge clk); while (!req.ready);
		pending_rsp.push_back(list_predict(op, value, pos));
	endtask

	// a handful of values that repeat often, so finds hit and duplicates occur
	function automatic logic signed [VALUE_W-1:0] pool_value();
		case ($urandom_range(7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return 32'sd0;
			3:       return -32'sd1;
			4:       return 32'sd1;
			5:       return 32'sd7;
			6:       return 32'sd42;
			default: return 32'sh55aa_55aa;
		endcase
	endfunction

	// random request, mostly with positions in range; the list drifts full and empty
	task automatic send_random_req();
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          pos;
		int                        r;
		if (model_len == CAPACITY)
			grow_list = 1'b0;
		else if (model_len == 0)
			grow_list = 1'b1;
		else if ($urandom_range(99) < 2)
			grow_list = !grow_list;
		r = $urandom_range(99);
		if (grow_list)
			op = (r < 30) ? OP_APPEND : (r < 60) ? OP_INSERT : (r < 75) ? OP_REMOVE : OP_FIND;
		else
			op = (r < 10) ? OP_APPEND : (r < 20) ? OP_INSERT : (r < 75) ? OP_REMOVE : OP_FIND;
		value = ($urandom_range(99) < 60) ? pool_value() : $urandom;
		pos   = POS_W'($urandom_range(31));
		case (op)
			OP_INSERT: begin
				if ($urandom_range(99) < 85)
					pos = POS_W'($urandom_range(model_len));
			end
			OP_REMOVE: begin
				if (model_len > 0 && $urandom_range(99) < 85)
					pos = POS_W'($urandom_range(model_len - 1));
			end
			OP_FIND: begin
				if (model_len > 0 && $urandom_range(99) < 60)
					value = model_vals[$urandom_range(model_len - 1)];
			end
			default: ;
		endcase
		send_req(op, value, pos);
	endtask

	// requests against an empty list
	task automatic test_empty_list();
		send_req(OP_FIND, 32'sd0, 5'd0);
		send_req(OP_REMOVE, 32'sd0, 5'd0);
		send_req(OP_INSERT, -32'sd1, 5'd31);
	endtask

	// each op, value extremes, duplicates and the end positions
	task automatic test_basic_ops();
		send_req(OP_APPEND, 32'sh8000_0000, 5'd0);
		send_req(OP_APPEND, 32'sh7fff_ffff, 5'd31);
		send_req(OP_INSERT, -32'sd1, 5'd0);
		send_req(OP_INSERT, 32'sd0, 5'd3);
		send_req(OP_INSERT, 32'sh7fff_ffff, 5'd1);
		send_req(OP_FIND, 32'sh7fff_ffff, 5'd0);
		send_req(OP_FIND, 32'sd12345, 5'd0);
		send_req(OP_REMOVE, 32'sd0, 5'd5);
		send_req(OP_REMOVE, 32'sd0, 5'd4);
	endtask

	// fill to capacity, then a find and requests that the full list must refuse
	task automatic test_full_list();
		while (model_len < CAPACITY)
			send_req(OP_APPEND, $urandom, 5'd0);
		send_req(OP_APPEND, 32'sd9, 5'd0);
		send_req(OP_INSERT, 32'sd9, 5'd31);
		send_req(OP_FIND, model_vals[CAPACITY-1], 5'd0);
		send_req(OP_REMOVE, 32'sd0, 5'd16);
	endtask

	task automatic test_random_traffic(int n);
		repeat (n) send_random_req();
	endtask

	// no gaps on either side
	task automatic test_back_to_back(int n);
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		repeat (n) send_random_req();
		req_idle_pct = IDLE_PCT;
		rsp_idle_pct = IDLE_PCT;
	endtask

	// long response stall while requests keep coming, so the input backs up
	task automatic test_output_stall(int n);
		req_idle_pct = 0;
		hold_requests++;
		repeat (n) send_random_req();
		req_idle_pct = IDLE_PCT;
	endtask

	// response ready: random stalls, plus a long hold when a test asks for one
	initial begin : rsp_ready_drive
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else
				rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	// compare every response beat with the oldest prediction
	always @(posedge clk) begin : rsp_check
		list_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response beat with no request outstanding");
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.found_position !== want.found_position) begin
					$error("found_position: expected %0d, got %0d",
						want.found_position, rsp.found_position);
					mismatches++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					mismatches++;
				end
				if (rsp.length !== want.length) begin
					$error("length: expected %0d, got %0d", want.length, rsp.length);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.op       = OP_APPEND;
		req.value    = '0;
		req.position = '0;
		model_len    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_basic_ops();
		test_full_list();
		test_random_traffic(1250);
		test_back_to_back(300);
		test_output_stall(100);
		test_random_traffic(50);

		req.valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule : tb
